### rtl/core/mbdtp_pkg.sv
// Shared types and constants for the memory bus with DMA, tile and palette logic.
// Used by every module of the block; depends on nothing else.
package mbdtp_pkg;

  localparam int DMA_LENGTH_DEF = 160;
  localparam int TILE_COUNT_DEF = 384;
  // Tiles whose rows lie in the writable tile area 8000-97FF.
  localparam int TILE_SPAN = 384;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int COLOR_W = 24;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] ADDR_DMA = 16'hFF46;
  localparam logic [15:0] ADDR_DMA_DEST = 16'hFE00;
  localparam logic [15:0] ADDR_TILE_BASE = 16'h8000;
  localparam logic [15:0] ADDR_PAL_BG = 16'hFF47;
  localparam logic [15:0] ADDR_PAL_OBJ0 = 16'hFF48;
  localparam logic [15:0] ADDR_PAL_OBJ1 = 16'hFF49;

  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_PIXEL = 2'd2;
  localparam logic [1:0] MODE_COLOR = 2'd3;

  localparam logic [1:0] PAL_BG = 2'd0;
  localparam logic [1:0] PAL_OBJ0 = 2'd1;
  localparam logic [1:0] PAL_OBJ1 = 2'd2;
  localparam logic [1:0] PAL_NONE = 2'd3;

  localparam logic [23:0] SHADE_RESET_0 = 24'hFFFFFF;
  localparam logic [23:0] SHADE_RESET_1 = 24'hAAAAAA;
  localparam logic [23:0] SHADE_RESET_2 = 24'h555555;
  localparam logic [23:0] SHADE_RESET_3 = 24'h000000;

  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic       en;
    logic [1:0] sel;
    logic [7:0] shades;
  } pal_wr_t;

endpackage

### rtl/core/mbdtp_bus_ram.sv
// Byte store of the 64 KiB bus: one write port, one registered read port.
// Runs a clearing pass after reset. Uses mbdtp_pkg.
module mbdtp_bus_ram (
  input  logic                clk,
  input  logic                rst,
  input  mbdtp_pkg::ram_wr_t  wr,
  input  logic [15:0]         raddr,
  output logic [7:0]          rdata,
  output logic                ready
);

  logic [7:0]  mem [65536];
  logic [15:0] clr_addr;
  logic        clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 16'd1;
      if (clr_addr == 16'hFFFF) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

  assign ready = !clearing;

endmodule

### rtl/core/mbdtp_palette.sv
// Shade color registers behind the configuration port and the three mapped palettes.
// Uses mbdtp_pkg.
module mbdtp_palette (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mbdtp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mbdtp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mbdtp_pkg::CFG_DATA_W-1:0]      prdata,
  input  mbdtp_pkg::pal_wr_t                    pal_wr,
  input  logic [1:0]                            rd_choice,
  input  logic [1:0]                            rd_slot,
  output logic [mbdtp_pkg::COLOR_W-1:0]         rd_color
);

  logic [23:0] shade [4];
  logic [23:0] pal [12];
  logic [1:0]  cfg_idx;

  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      shade[0] <= mbdtp_pkg::SHADE_RESET_0;
      shade[1] <= mbdtp_pkg::SHADE_RESET_1;
      shade[2] <= mbdtp_pkg::SHADE_RESET_2;
      shade[3] <= mbdtp_pkg::SHADE_RESET_3;
    end else if (psel && penable && pwrite) begin
      shade[cfg_idx] <= pwdata[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 12; i++) begin
        pal[i] <= '0;
      end
    end else if (pal_wr.en) begin
      for (int k = 0; k < 4; k++) begin
        pal[{pal_wr.sel, 2'(k)}] <= shade[pal_wr.shades[2*k +: 2]];
      end
    end
  end

  assign prdata = {8'd0, shade[cfg_idx]};
  assign rd_color = (rd_choice == mbdtp_pkg::PAL_NONE) ? 24'd0 : pal[{rd_choice, rd_slot}];

endmodule

### rtl/core/memory_bus_with_dma_tile_palette.sv
// Top level: stream item decoder and sequencer around the bus memory and palettes.
// Uses mbdtp_pkg, mbdtp_bus_ram and mbdtp_palette.
// Item states: byte read S_RD_REQ, S_RD_WAIT; tile pixel S_PX_LO, S_PX_HI, S_PX_WAIT;
// palette color S_PAL; plain write S_WR; write to FF46: DMA copy, then S_WR. All end in
// S_DONE; one item is worked on at a time. DMA reads and writes each byte in turn.
// After reset a clearing pass zeroes the bus memory with s_tready low.
module memory_bus_with_dma_tile_palette #(
  parameter int DMA_LENGTH = mbdtp_pkg::DMA_LENGTH_DEF,
  parameter int TILE_COUNT = mbdtp_pkg::TILE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // mode[1:0], address[17:2], write_data[25:18], tile_number[34:26],
  // tile_row[37:35], tile_column[40:38], palette_choice[42:41], palette_slot[44:43]
  input  logic [47:0]                       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // read_data[7:0], tile_pixel[9:8], palette_color[33:10]
  output logic [39:0]                       m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbdtp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mbdtp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mbdtp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int CntW = (DMA_LENGTH > 1) ? $clog2(DMA_LENGTH) : 1;
  localparam int TileLimit = (TILE_COUNT < mbdtp_pkg::TILE_SPAN) ? TILE_COUNT
                                                                  : mbdtp_pkg::TILE_SPAN;
  localparam logic [CntW-1:0] CntLast = CntW'(DMA_LENGTH - 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD_REQ  = 4'd1;
  localparam logic [3:0] S_RD_WAIT = 4'd2;
  localparam logic [3:0] S_PX_LO   = 4'd3;
  localparam logic [3:0] S_PX_HI   = 4'd4;
  localparam logic [3:0] S_PX_WAIT = 4'd5;
  localparam logic [3:0] S_PAL     = 4'd6;
  localparam logic [3:0] S_DMA_RD  = 4'd7;
  localparam logic [3:0] S_DMA_WR  = 4'd8;
  localparam logic [3:0] S_WR      = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]      state;
  logic [3:0]      state_next;
  logic [15:0]     address;
  logic [7:0]      write_data;
  logic [8:0]      tile_number;
  logic [2:0]      tile_row;
  logic [2:0]      tile_column;
  logic [1:0]      palette_choice;
  logic [1:0]      palette_slot;
  logic [CntW-1:0] cnt;
  logic [7:0]      lo_byte;
  logic [7:0]      res_read;
  logic [1:0]      res_pixel;
  logic [23:0]     res_color;

  mbdtp_pkg::ram_wr_t ram_wr;
  mbdtp_pkg::pal_wr_t pal_wr;
  logic [15:0]        ram_raddr;
  logic [7:0]         ram_rdata;
  logic               ram_ready;
  logic [23:0]        pal_color;
  logic [15:0]        px_addr;
  logic               accept;
  logic               out_free;

  mbdtp_bus_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .ready (ram_ready)
  );

  mbdtp_palette u_pal (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pal_wr    (pal_wr),
    .rd_choice (palette_choice),
    .rd_slot   (palette_slot),
    .rd_color  (pal_color)
  );

  assign pready = 1'b1;
  assign s_tready = (state == S_IDLE) && ram_ready;
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign px_addr = mbdtp_pkg::ADDR_TILE_BASE + {3'd0, tile_number, tile_row, 1'b0};

  always_comb begin
    case (state)
      S_RD_REQ: ram_raddr = address;
      S_PX_LO:  ram_raddr = px_addr;
      S_PX_HI:  ram_raddr = px_addr | 16'd1;
      S_DMA_RD: ram_raddr = {write_data, 8'd0} + 16'(cnt);
      default:  ram_raddr = address;
    endcase
  end

  always_comb begin
    ram_wr.en = 1'b0;
    ram_wr.addr = address;
    ram_wr.data = write_data;
    pal_wr.en = 1'b0;
    pal_wr.sel = mbdtp_pkg::PAL_BG;
    pal_wr.shades = write_data;
    if (state == S_DMA_WR) begin
      ram_wr.en = 1'b1;
      ram_wr.addr = mbdtp_pkg::ADDR_DMA_DEST + 16'(cnt);
      ram_wr.data = ram_rdata;
    end else if (state == S_WR) begin
      ram_wr.en = 1'b1;
      if (address == mbdtp_pkg::ADDR_PAL_BG) begin
        pal_wr.en = 1'b1;
        pal_wr.sel = mbdtp_pkg::PAL_BG;
      end else if (address == mbdtp_pkg::ADDR_PAL_OBJ0) begin
        pal_wr.en = 1'b1;
        pal_wr.sel = mbdtp_pkg::PAL_OBJ0;
      end else if (address == mbdtp_pkg::ADDR_PAL_OBJ1) begin
        pal_wr.en = 1'b1;
        pal_wr.sel = mbdtp_pkg::PAL_OBJ1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tdata[1:0])
            mbdtp_pkg::MODE_READ: state_next = S_RD_REQ;
            mbdtp_pkg::MODE_WRITE: begin
              state_next = (s_tdata[17:2] == mbdtp_pkg::ADDR_DMA) ? S_DMA_RD : S_WR;
            end
            mbdtp_pkg::MODE_PIXEL: begin
              state_next = (s_tdata[34:26] < 9'(TileLimit)) ? S_PX_LO : S_DONE;
            end
            default: state_next = S_PAL;
          endcase
        end
      end
      S_RD_REQ:  state_next = S_RD_WAIT;
      S_RD_WAIT: state_next = S_DONE;
      S_PX_LO:   state_next = S_PX_HI;
      S_PX_HI:   state_next = S_PX_WAIT;
      S_PX_WAIT: state_next = S_DONE;
      S_PAL:     state_next = S_DONE;
      S_DMA_RD:  state_next = S_DMA_WR;
      S_DMA_WR:  state_next = (cnt == CntLast) ? S_WR : S_DMA_RD;
      S_WR:      state_next = S_DONE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      address <= s_tdata[17:2];
      write_data <= s_tdata[25:18];
      tile_number <= s_tdata[34:26];
      tile_row <= s_tdata[37:35];
      tile_column <= s_tdata[40:38];
      palette_choice <= s_tdata[42:41];
      palette_slot <= s_tdata[44:43];
      res_read <= '0;
      res_pixel <= '0;
      res_color <= '0;
      cnt <= '0;
    end
    case (state)
      S_RD_WAIT: res_read <= ram_rdata;
      S_PX_HI:   lo_byte <= ram_rdata;
      S_PX_WAIT: res_pixel <= {ram_rdata[~tile_column], lo_byte[~tile_column]};
      S_PAL:     res_color <= pal_color;
      S_DMA_WR:  cnt <= cnt + CntW'(1);
      default: begin
      end
    endcase
    if (state == S_DONE && out_free) begin
      m_tdata <= {6'd0, res_color, res_pixel, res_read};
    end
  end

endmodule
